### sv/fslet_pkg.sv
`default_nettype none

package fslet_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int PAT_W   = 5;
    localparam int HEAD_W  = 16;
    localparam int TURN_W  = 2;
    localparam int ERR_W   = 14;
    localparam int CNT_W   = 8;
    localparam int CFG_W   = 8;
    localparam int STEP_W  = 5;
    localparam int SUM_W   = ERR_W + 1;
    localparam int DEV_W   = HEAD_W + 1;

    localparam logic [PAT_W-1:0] PAT_NONE    = 5'h00;
    localparam logic [PAT_W-1:0] PAT_RIGHT2  = 5'h02;
    localparam logic [PAT_W-1:0] PAT_CENTRE  = 5'h04;
    localparam logic [PAT_W-1:0] PAT_RIGHT1  = 5'h06;
    localparam logic [PAT_W-1:0] PAT_LEFT2   = 5'h08;
    localparam logic [PAT_W-1:0] PAT_CROSS   = 5'h0A;
    localparam logic [PAT_W-1:0] PAT_LEFT1   = 5'h0C;
    localparam logic [PAT_W-1:0] PAT_STOP    = 5'h0E;
    localparam logic [PAT_W-1:0] PAT_ALL     = 5'h1F;

    localparam logic [TURN_W-1:0] TURN_LEFT  = 2'd0;
    localparam logic [TURN_W-1:0] TURN_RIGHT = 2'd1;

    localparam logic CFG_LAP_LIMIT      = 1'b0;
    localparam logic CFG_DEBOUNCE_LIMIT = 1'b1;

    typedef enum logic [3:0] {
        OP_HOLD,
        OP_DRIFT,
        OP_RIGHT2,
        OP_RIGHT1,
        OP_LEFT1,
        OP_LEFT2,
        OP_CENTRE,
        OP_STOPLINE,
        OP_ALLON
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic                     clear;
        logic signed [HEAD_W-1:0] heading;
    } cmd_t;

    typedef struct packed {
        logic signed [ERR_W-1:0] steering_error;
        logic                    stop_request;
        logic [CNT_W-1:0]        laps_seen;
    } res_t;

endpackage

`default_nettype wire

### sv/fslet_queue.sv
`default_nettype none

module fslet_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] data_in,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      data_out,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= data_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### sv/fslet_front.sv
`default_nettype none

module fslet_front (
    input  wire logic [fslet_pkg::PAT_W-1:0]         sensor_bits,
    input  wire logic signed [fslet_pkg::HEAD_W-1:0] heading,
    input  wire logic [fslet_pkg::TURN_W-1:0]        crossing_turn,
    output fslet_pkg::cmd_t                          cmd
);

    import fslet_pkg::*;

    always_comb
    begin
        cmd.op      = OP_HOLD;
        cmd.clear   = 1'b0;
        cmd.heading = heading;
        case (sensor_bits)
            PAT_NONE:   cmd.op = OP_DRIFT;
            PAT_RIGHT2: cmd.op = OP_RIGHT2;
            PAT_RIGHT1: cmd.op = OP_RIGHT1;
            PAT_CENTRE: cmd.op = OP_CENTRE;
            PAT_LEFT1:  cmd.op = OP_LEFT1;
            PAT_LEFT2:  cmd.op = OP_LEFT2;
            PAT_STOP:   cmd.op = OP_STOPLINE;
            PAT_ALL:    cmd.op = OP_ALLON;
            PAT_CROSS:
            begin
                if (crossing_turn == TURN_LEFT)
                begin
                    cmd.op    = OP_LEFT2;
                    cmd.clear = 1'b1;
                end
                else if (crossing_turn == TURN_RIGHT)
                begin
                    cmd.op    = OP_RIGHT2;
                    cmd.clear = 1'b1;
                end
            end
            default:    cmd.op = OP_HOLD;
        endcase
    end

endmodule

`default_nettype wire

### sv/fslet_back.sv
`default_nettype none

module fslet_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write,
    input  wire logic                        cfg_addr,
    input  wire logic [fslet_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                        cmd_valid,
    input  wire fslet_pkg::cmd_t             cmd,
    output logic                             cmd_pop,
    input  wire logic                        res_full,
    output logic                             res_push,
    output fslet_pkg::res_t                  res
);

    import fslet_pkg::*;

    logic [CFG_W-1:0]         lap_limit_reg;
    logic [CFG_W-1:0]         debounce_limit_reg;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic signed [HEAD_W-1:0] target_reg, target_next;
    logic [CNT_W-1:0]         dbc_reg, dbc_next;
    logic [CNT_W-1:0]         lap_reg, lap_next;
    logic                     stop;
    logic                     fire;

    assign fire     = cmd_valid && !res_full;
    assign cmd_pop  = fire;
    assign res_push = fire;

    always_comb
    begin
        logic signed [DEV_W-1:0]  dev;
        logic signed [ERR_W-1:0]  base;
        logic signed [STEP_W-1:0] step;
        logic signed [SUM_W-1:0]  lo;
        logic signed [SUM_W-1:0]  hi;
        logic signed [SUM_W-1:0]  sum;
        logic                     upd;
        logic [CNT_W:0]           d;
        logic [CNT_W:0]           l;

        dev  = DEV_W'(cmd.heading) - DEV_W'(target_reg);
        base = cmd.clear ? '0 : err_reg;
        step = '0;
        lo   = '0;
        hi   = '0;
        upd  = 1'b0;
        d    = '0;
        l    = '0;

        err_next    = err_reg;
        target_next = target_reg;
        dbc_next    = dbc_reg;
        lap_next    = lap_reg;
        stop        = 1'b0;

        case (cmd.op)
            OP_DRIFT:
            begin
                if (dev < 0)
                begin
                    if (dev > -17'sd2200 && dev < -17'sd1200)
                    begin
                        upd = 1'b1; step = 5'sd4;  lo = 15'sd2400; hi = 15'sd3400;
                    end
                    else if (dev < -17'sd3400)
                    begin
                        upd = 1'b1; step = 5'sd10; lo = -15'sd8000; hi = 15'sd8000;
                    end
                end
                else if (dev > 0)
                begin
                    if (dev > 17'sd1200 && dev < 17'sd2200)
                    begin
                        upd = 1'b1; step = -5'sd4;  lo = -15'sd3400; hi = -15'sd2400;
                    end
                    else if (dev > 17'sd3400)
                    begin
                        upd = 1'b1; step = -5'sd10; lo = -15'sd8000; hi = 15'sd8000;
                    end
                end
            end
            OP_RIGHT2:
            begin
                upd = 1'b1; step = -5'sd2; lo = -15'sd2300; hi = -15'sd1200;
            end
            OP_RIGHT1:
            begin
                upd = 1'b1; step = -5'sd1; lo = -15'sd1200; hi = -15'sd700;
            end
            OP_LEFT1:
            begin
                upd = 1'b1; step = 5'sd1; lo = 15'sd700; hi = 15'sd1200;
            end
            OP_LEFT2:
            begin
                upd = 1'b1; step = 5'sd2; lo = 15'sd1200; hi = 15'sd2300;
            end
            OP_CENTRE:
            begin
                err_next    = '0;
                target_next = cmd.heading;
                dbc_next    = '0;
            end
            OP_STOPLINE:
            begin
                if (err_reg > -14'sd710 && err_reg < 14'sd710)
                begin
                    d = {1'b0, dbc_reg} + 1'b1;
                    if (d >= {1'b0, debounce_limit_reg})
                    begin
                        l = {1'b0, lap_reg} + 1'b1;
                        if (l >= {1'b0, lap_limit_reg})
                        begin
                            stop = 1'b1;
                            l    = '0;
                        end
                        lap_next = l[CNT_W-1:0];
                        d        = '0;
                    end
                    dbc_next = d[CNT_W-1:0];
                end
            end
            OP_ALLON:
            begin
                stop = 1'b1;
            end
            default:
            begin
                upd = 1'b0;
            end
        endcase

        sum = SUM_W'(base) + SUM_W'(step);
        if (upd)
        begin
            if (sum < lo)
            begin
                err_next = lo[ERR_W-1:0];
            end
            else if (sum > hi)
            begin
                err_next = hi[ERR_W-1:0];
            end
            else
            begin
                err_next = sum[ERR_W-1:0];
            end
        end

        res.steering_error = err_next;
        res.stop_request   = stop;
        res.laps_seen      = lap_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lap_limit_reg      <= '0;
            debounce_limit_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_addr)
                CFG_LAP_LIMIT:      lap_limit_reg      <= cfg_data;
                CFG_DEBOUNCE_LIMIT: debounce_limit_reg <= cfg_data;
                default:            lap_limit_reg      <= lap_limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg    <= '0;
            target_reg <= '0;
            dbc_reg    <= '0;
            lap_reg    <= '0;
        end
        else if (fire)
        begin
            err_reg    <= err_next;
            target_reg <= target_next;
            dbc_reg    <= dbc_next;
            lap_reg    <= lap_next;
        end
    end

endmodule

`default_nettype wire

### sv/five_sensor_line_error_tracker_core.sv
// Command and result queues of CMD_DEPTH and RES_DEPTH entries hold each pushed
// item and then its result. Throughput: one item per cycle while the result
// queue is not full, set by the combinational error update in the execution stage.
// Reset (rst_n low, asynchronous): queues empty, error, target heading, debounce
// and lap counts cleared, both limits zero.
`default_nettype none

module five_sensor_line_error_tracker_core #(
    parameter int CMD_DEPTH = fslet_pkg::QUEUE_DEPTH,
    parameter int RES_DEPTH = fslet_pkg::QUEUE_DEPTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [fslet_pkg::PAT_W-1:0]        sensor_bits,
    input  wire logic signed [fslet_pkg::HEAD_W-1:0] heading,
    input  wire logic [fslet_pkg::TURN_W-1:0]       crossing_turn,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic signed [fslet_pkg::ERR_W-1:0]      steering_error,
    output logic                                    stop_request,
    output logic [fslet_pkg::CNT_W-1:0]             laps_seen,
    input  wire logic                               cfg_write,
    input  wire logic                               cfg_addr,
    input  wire logic [fslet_pkg::CFG_W-1:0]        cfg_data
);

    import fslet_pkg::*;

    cmd_t cmd_in;
    cmd_t cmd_out;
    logic cmd_empty;
    logic cmd_pop;
    res_t res_in;
    res_t res_out;
    logic res_full;
    logic res_push;

    fslet_front u_front (
        .sensor_bits   (sensor_bits),
        .heading       (heading),
        .crossing_turn (crossing_turn),
        .cmd           (cmd_in)
    );

    fslet_queue #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .data_in  (cmd_in),
        .full     (full),
        .pop      (cmd_pop),
        .data_out (cmd_out),
        .empty    (cmd_empty)
    );

    fslet_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cmd_valid (!cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    fslet_queue #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_push),
        .data_in  (res_in),
        .full     (res_full),
        .pop      (pop),
        .data_out (res_out),
        .empty    (empty)
    );

    assign steering_error = res_out.steering_error;
    assign stop_request   = res_out.stop_request;
    assign laps_seen      = res_out.laps_seen;

endmodule

`default_nettype wire
